// ----- rtl/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the drum step sequencer: payload structs,
// request codes, MIDI message constants and the controller/datapath link.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int INSTRUMENTS_DEF = 32;
    localparam int MAX_STEPS_DEF   = 128;

    // Field widths fixed by the item format
    localparam int INST_W   = 5;
    localparam int STEP_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_STOP  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_IN_LOOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_VELOCITY = 2'd1;

    localparam logic [7:0] STEPS_IN_LOOP_RST = 8'd16;
    localparam logic [6:0] NOTE_VELOCITY_RST = 7'd127;

    // MIDI channel 10 messages
    localparam logic [7:0] ST_NOTE_OFF   = 8'h89;
    localparam logic [7:0] ST_NOTE_ON    = 8'h99;
    localparam logic [7:0] ST_PROGRAM    = 8'hC9;
    localparam logic [7:0] ST_CONTROL    = 8'hB9;
    localparam logic [6:0] FIRST_NOTE    = 7'd35;
    localparam logic [6:0] ALL_NOTES_OFF = 7'd123;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [INST_W-1:0] cell_instrument;
        logic [STEP_W-1:0] cell_step;
        logic              cell_value;
    } req_item_t;

    typedef struct packed {
        logic [7:0]        midi_status;
        logic [6:0]        midi_data1;
        logic [6:0]        midi_data2;
        logic [STEP_W-1:0] step_index;
        logic              last;
    } midi_msg_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // latch request, apply start/stop
        logic div_start;    // load (step + 1) into the remainder unit
        logic div_step;     // one remainder iteration
        logic rd_prev;      // read previous column, advance the steps
        logic rd_cur;       // read current column, capture note-off row
        logic cap_on;       // capture note-on row
        logic rd_cell;      // read column of a cell write
        logic wr_cell;      // write modified column back
        logic emit_single;  // program change or all-notes-off
        logic emit_scan;    // next note-off / note-on from the captured rows
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic playing;
        logic started;
        logic div_last;
        logic out_free;
        logic scan_empty;
        logic scan_last;
    } dp_status_t;

endpackage

// ----- rtl/dss_ctrl.sv -----
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer controller: takes one request at a time and steps the datapath
// through remainder, column reads, cell writes and message emission.
// ----------------------------------------------------------------------------
module dss_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_type,
    output logic               req_ready,
    input  dss_pkg::dp_status_t status,
    output dss_pkg::dp_cmd_t    cmd
);
    import dss_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIV    = 9'b000000010,
        S_RD_OFF = 9'b000000100,
        S_RD_ON  = 9'b000001000,
        S_CAP    = 9'b000010000,
        S_EMIT   = 9'b000100000,
        S_WR_RD  = 9'b001000000,
        S_WR     = 9'b010000000,
        S_MSG    = 9'b100000000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.accept      = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_TICK:
                        begin
                            if (!status.playing)
                                state_next = S_IDLE;
                            else if (status.started)
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = S_DIV;
                            end
                            else
                                state_next = S_RD_OFF;
                        end
                        REQ_WRITE: state_next = S_WR_RD;
                        default:   state_next = S_MSG;
                    endcase
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_RD_OFF;
            end
            S_RD_OFF:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = S_RD_ON;
            end
            S_RD_ON:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap_on = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_scan = 1'b1;
                if (status.scan_empty || (status.out_free && status.scan_last))
                    state_next = S_IDLE;
            end
            S_WR_RD:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                cmd.wr_cell = 1'b1;
                state_next  = S_IDLE;
            end
            S_MSG:
            begin
                cmd.emit_single = 1'b1;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/dss_datapath.sv -----
// ----------------------------------------------------------------------------
// dss_datapath
// Pattern memory, step registers, loop remainder unit, column scanners and
// the output message register.
// ----------------------------------------------------------------------------
module dss_datapath
#(
    parameter int INSTRUMENTS = dss_pkg::INSTRUMENTS_DEF,
    parameter int MAX_STEPS   = dss_pkg::MAX_STEPS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dss_pkg::req_item_t                   req,
    input  logic                                 cfg_valid,
    input  logic [dss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]       cfg_data,
    output dss_pkg::midi_msg_t                   msg,
    output logic                                 msg_valid,
    input  logic                                 msg_ready,
    input  dss_pkg::dp_cmd_t                     cmd,
    output dss_pkg::dp_status_t                  status
);
    import dss_pkg::*;

    localparam int STEP_AW = $clog2(MAX_STEPS);
    localparam logic [7:0] MAX_STEPS_B = 8'(MAX_STEPS);
    localparam logic [INST_W:0] INSTRUMENTS_B = (INST_W+1)'(INSTRUMENTS);

    // Configuration
    logic [7:0] steps_in_loop_reg;
    logic [6:0] note_velocity_reg;
    logic [7:0] loop_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_in_loop_reg <= STEPS_IN_LOOP_RST;
            note_velocity_reg <= NOTE_VELOCITY_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_STEPS_IN_LOOP)
                steps_in_loop_reg <= cfg_data;
            else if (cfg_index == CFG_NOTE_VELOCITY)
                note_velocity_reg <= cfg_data[6:0];
        end
    end

    always_comb
    begin
        if (steps_in_loop_reg == 8'd0)
            loop_len = 8'd1;
        else if (steps_in_loop_reg > MAX_STEPS_B)
            loop_len = MAX_STEPS_B;
        else
            loop_len = steps_in_loop_reg;
    end

    // Latched request
    req_item_t req_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            req_reg <= req;
    end

    // Sequencer state
    logic              playing_reg;
    logic              started_reg;
    logic              off_en_reg;
    logic [STEP_W-1:0] cur_reg;
    logic [STEP_W-1:0] prev_reg;

    // Remainder unit: (cur + 1) mod loop_len, one quotient bit per cycle
    logic [7:0] div_q_reg;
    logic [7:0] div_rem_reg;
    logic [2:0] div_cnt_reg;
    logic [8:0] div_trial;
    logic [8:0] div_diff;

    assign div_trial = {div_rem_reg, div_q_reg[7]};
    assign div_diff  = div_trial - {1'b0, loop_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_start)
            div_cnt_reg <= '0;
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_q_reg   <= {1'b0, cur_reg} + 8'd1;
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_q_reg <= {div_q_reg[6:0], 1'b0};
            if (div_trial >= {1'b0, loop_len})
                div_rem_reg <= div_diff[7:0];
            else
                div_rem_reg <= div_trial[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= 1'b0;
            started_reg <= 1'b0;
            off_en_reg  <= 1'b0;
            cur_reg     <= '0;
            prev_reg    <= '0;
        end
        else if (cmd.accept && req.req_type == REQ_START)
        begin
            playing_reg <= 1'b1;
            started_reg <= 1'b0;
            cur_reg     <= '0;
        end
        else if (cmd.accept && req.req_type == REQ_STOP)
        begin
            playing_reg <= 1'b0;
            started_reg <= 1'b0;
            cur_reg     <= '0;
            prev_reg    <= '0;
        end
        else if (cmd.rd_prev)
        begin
            // previous takes the old current only once a step has played
            off_en_reg <= started_reg;
            if (started_reg)
            begin
                prev_reg <= cur_reg;
                cur_reg  <= div_rem_reg[STEP_W-1:0];
            end
            else
            begin
                cur_reg     <= '0;
                started_reg <= 1'b1;
            end
        end
    end

    // Pattern memory with one valid bit per column; invalid columns read as 0
    logic [INSTRUMENTS-1:0] grid_mem [MAX_STEPS];
    logic [MAX_STEPS-1:0]   col_valid_reg;
    logic [INSTRUMENTS-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic                   rd_en;
    logic [STEP_AW-1:0]     rd_addr;
    logic [STEP_AW-1:0]     wr_addr;
    logic [INSTRUMENTS-1:0] rd_row;
    logic [INSTRUMENTS-1:0] cell_mask;
    logic [INSTRUMENTS-1:0] wr_row;
    logic                   cell_ok;

    always_comb
    begin
        if (cmd.rd_prev)
            rd_addr = prev_reg[STEP_AW-1:0];
        else if (cmd.rd_cur)
            rd_addr = cur_reg[STEP_AW-1:0];
        else
            rd_addr = req_reg.cell_step[STEP_AW-1:0];
    end

    assign rd_en   = cmd.rd_prev || cmd.rd_cur || cmd.rd_cell;
    assign wr_addr = req_reg.cell_step[STEP_AW-1:0];
    assign rd_row  = rd_valid_reg ? rd_data_reg : '0;
    assign cell_ok = ({1'b0, req_reg.cell_instrument} < INSTRUMENTS_B)
                  && ({1'b0, req_reg.cell_step} < MAX_STEPS_B);

    always_comb
    begin
        for (int i = 0; i < INSTRUMENTS; i++)
            cell_mask[i] = (req_reg.cell_instrument == INST_W'(i));
    end

    assign wr_row = req_reg.cell_value ? (rd_row | cell_mask) : (rd_row & ~cell_mask);

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= grid_mem[rd_addr];
        if (cmd.wr_cell && cell_ok)
            grid_mem[wr_addr] <= wr_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rd_valid_reg <= col_valid_reg[rd_addr];
            if (cmd.wr_cell && cell_ok)
                col_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Column scanners: note-offs drain first, then note-ons
    logic [INSTRUMENTS-1:0] off_bits_reg;
    logic [INSTRUMENTS-1:0] on_bits_reg;
    logic [INSTRUMENTS-1:0] scan_bits;
    logic [INSTRUMENTS-1:0] scan_rest;
    logic [INST_W-1:0]      scan_idx;
    logic                   scan_off;
    logic                   emit_scan;
    logic                   emit_single;
    logic                   out_free;

    assign scan_off  = (off_bits_reg != '0);
    assign scan_bits = scan_off ? off_bits_reg : on_bits_reg;
    assign scan_rest = scan_bits & (scan_bits - INSTRUMENTS'(1));

    always_comb
    begin
        scan_idx = '0;
        for (int i = INSTRUMENTS - 1; i >= 0; i--)
        begin
            if (scan_bits[i])
                scan_idx = INST_W'(i);
        end
    end

    assign out_free    = !msg_valid || msg_ready;
    assign emit_scan   = cmd.emit_scan && out_free && (scan_bits != '0);
    assign emit_single = cmd.emit_single && out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_cur)
            off_bits_reg <= off_en_reg ? rd_row : '0;
        else if (emit_scan && scan_off)
            off_bits_reg <= scan_rest;

        if (cmd.cap_on)
            on_bits_reg <= rd_row;
        else if (emit_scan && !scan_off)
            on_bits_reg <= scan_rest;
    end

    // Output register
    midi_msg_t msg_reg;
    logic      msg_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            msg_valid_reg <= 1'b0;
        else if (emit_scan || emit_single)
            msg_valid_reg <= 1'b1;
        else if (msg_ready)
            msg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_scan)
        begin
            msg_reg.midi_status <= scan_off ? ST_NOTE_OFF : ST_NOTE_ON;
            msg_reg.midi_data1  <= FIRST_NOTE + {2'b00, scan_idx};
            msg_reg.midi_data2  <= scan_off ? 7'd0 : note_velocity_reg;
            msg_reg.step_index  <= cur_reg;
            msg_reg.last        <= scan_off ? (scan_rest == '0 && on_bits_reg == '0)
                                            : (scan_rest == '0);
        end
        else if (emit_single)
        begin
            msg_reg.midi_status <= (req_reg.req_type == REQ_START) ? ST_PROGRAM : ST_CONTROL;
            msg_reg.midi_data1  <= (req_reg.req_type == REQ_START) ? 7'd0 : ALL_NOTES_OFF;
            msg_reg.midi_data2  <= 7'd0;
            msg_reg.step_index  <= cur_reg;
            msg_reg.last        <= 1'b1;
        end
    end

    assign msg       = msg_reg;
    assign msg_valid = msg_valid_reg;

    assign status.playing    = playing_reg;
    assign status.started    = started_reg;
    assign status.div_last   = (div_cnt_reg == 3'd7);
    assign status.out_free   = out_free;
    assign status.scan_empty = (scan_bits == '0);
    assign status.scan_last  = scan_off ? (scan_rest == '0 && on_bits_reg == '0)
                                        : (scan_rest == '0);

endmodule

// ----- rtl/drum_step_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// drum_step_sequencer_core
// Drum pattern step sequencer: plays an instrument-by-step grid as MIDI
// channel-10 percussion messages.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready): tick, cell write, start or stop. One request
//   is in work at a time; req_ready is high while the controller is idle.
//   msg channel (valid/ready): one MIDI message per transfer, last marks the
//   final message of a request. A request with no messages (cell write,
//   tick while stopped, tick on empty columns) simply finishes.
//   cfg channel (valid/ready): cfg_ready is always high; write only while idle.
// Work per request:
//   start/stop: one message from the message state. cell write: read-modify-
//   write of one column. tick: setup (loop remainder, two column reads), then
//   one message per cycle while the receiver takes them, up to 2*INSTRUMENTS;
//   a first tick after start skips the remainder.
//   The message register lets the next request in while the last message
//   still waits; a stalled receiver holds the scan one message at a time.
// Reset: pattern cleared at once through per-column valid bits, playback
//   stopped, steps zero, steps_in_loop 16, note_velocity 127.
// ----------------------------------------------------------------------------
module drum_step_sequencer_core
#(
    parameter int INSTRUMENTS = dss_pkg::INSTRUMENTS_DEF,
    parameter int MAX_STEPS   = dss_pkg::MAX_STEPS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  dss_pkg::req_item_t             req,
    output logic                           msg_valid,
    input  logic                           msg_ready,
    output dss_pkg::midi_msg_t             msg,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dss_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    dss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dss_datapath
    #(
        .INSTRUMENTS (INSTRUMENTS),
        .MAX_STEPS   (MAX_STEPS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .msg       (msg),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- test/dss_checker.sv -----
// ----------------------------------------------------------------------------
// dss_checker
// Watches the request, message and register channels of the drum step
// sequencer and keeps its own copy of the pattern grid, steps and registers.
// Each accepted request queues the MIDI messages it should cause, and each
// message transfer is compared field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module dss_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  dss_pkg::req_item_t             req,
    input  logic                           msg_valid,
    input  logic                           msg_ready,
    input  dss_pkg::midi_msg_t             msg,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    localparam int INSTRUMENTS = INSTRUMENTS_DEF;
    localparam int MAX_STEPS   = MAX_STEPS_DEF;

    logic [INSTRUMENTS-1:0] grid [0:MAX_STEPS-1];
    logic [STEP_W-1:0]      cur_step;
    logic [STEP_W-1:0]      prev_step;
    logic                   started;
    logic                   playing;
    logic [7:0]             loop_reg;
    logic [6:0]             velocity;

    midi_msg_t new_msgs[$];
    midi_msg_t due_msgs[$];

    function automatic int loop_length();
        if (loop_reg == 8'd0)
            return 1;
        if (int'(loop_reg) > MAX_STEPS)
            return MAX_STEPS;
        return int'(loop_reg);
    endfunction

    function automatic void queue_column(input logic [STEP_W-1:0] col, input logic note_on);
        midi_msg_t m;
        int        i;
        for (i = 0; i < INSTRUMENTS; i++)
        begin
            if (grid[col][i])
            begin
                m             = '0;
                m.midi_status = note_on ? ST_NOTE_ON : ST_NOTE_OFF;
                m.midi_data1  = FIRST_NOTE + 7'(i);
                m.midi_data2  = note_on ? velocity : 7'd0;
                new_msgs.push_back(m);
            end
        end
    endfunction

    function automatic void queue_single(input logic [7:0] status, input logic [6:0] data1);
        midi_msg_t m;
        m             = '0;
        m.midi_status = status;
        m.midi_data1  = data1;
        new_msgs.push_back(m);
    endfunction

    // Update the model state for one request and queue the messages it causes
    function automatic void play_request(input req_item_t r);
        int j;
        new_msgs.delete();
        case (r.req_type)
            REQ_TICK:
            begin
                if (playing)
                begin
                    if (started)
                    begin
                        // note-offs come from the lagging column
                        queue_column(prev_step, 1'b0);
                        prev_step = cur_step;
                        cur_step  = STEP_W'((int'(cur_step) + 1) % loop_length());
                    end
                    else
                    begin
                        cur_step = '0;
                        started  = 1'b1;
                    end
                    queue_column(cur_step, 1'b1);
                end
            end
            REQ_WRITE:
            begin
                if (int'(r.cell_instrument) < INSTRUMENTS && int'(r.cell_step) < MAX_STEPS)
                    grid[r.cell_step][r.cell_instrument] = r.cell_value;
            end
            REQ_START:
            begin
                queue_single(ST_PROGRAM, 7'd0);
                playing  = 1'b1;
                started  = 1'b0;
                cur_step = '0;
            end
            default:
            begin
                queue_single(ST_CONTROL, ALL_NOTES_OFF);
                playing   = 1'b0;
                started   = 1'b0;
                cur_step  = '0;
                prev_step = '0;
            end
        endcase
        for (j = 0; j < new_msgs.size(); j++)
        begin
            new_msgs[j].step_index = cur_step;
            new_msgs[j].last       = (j == new_msgs.size() - 1);
            due_msgs.push_back(new_msgs[j]);
        end
    endfunction

    function automatic void check_message(input midi_msg_t got);
        midi_msg_t want;
        if (due_msgs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected message st=%h d1=%0d d2=%0d step=%0d last=%0b",
                         $realtime, got.midi_status, got.midi_data1, got.midi_data2,
                         got.step_index, got.last);
            return;
        end
        want = due_msgs.pop_front();
        if (got.midi_status !== want.midi_status || got.midi_data1 !== want.midi_data1 ||
            got.midi_data2 !== want.midi_data2 || got.step_index !== want.step_index ||
            got.last !== want.last)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: message mismatch: expected st=%h d1=%0d d2=%0d step=%0d last=%0b",
                         $realtime, want.midi_status, want.midi_data1, want.midi_data2,
                         want.step_index, want.last);
                $display("%0t:                   got st=%h d1=%0d d2=%0d step=%0d last=%0b",
                         $realtime, got.midi_status, got.midi_data1, got.midi_data2,
                         got.step_index, got.last);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_STEPS; s++)
                grid[s] = '0;
            cur_step   = '0;
            prev_step  = '0;
            started    = 1'b0;
            playing    = 1'b0;
            loop_reg   = STEPS_IN_LOOP_RST;
            velocity   = NOTE_VELOCITY_RST;
            mismatches = 0;
            due_msgs.delete();
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_STEPS_IN_LOOP)
                    loop_reg = cfg_data;
                else if (cfg_index == CFG_NOTE_VELOCITY)
                    velocity = cfg_data[6:0];
            end
            // messages on this edge belong to earlier requests
            if (msg_valid && msg_ready)
                check_message(msg);
            if (req_valid && req_ready)
                play_request(req);
            pending <= due_msgs.size();
        end
    end

endmodule

// ----- test/tb_drum_step_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// tb_drum_step_sequencer_core
// Drives cell writes, starts, stops and ticks into the drum step sequencer
// under random idle gaps on both channels, changes the loop length and note
// velocity between phases, and forces a long receiver stall with full
// columns. The checker beside the block predicts and compares every message.
// ----------------------------------------------------------------------------
module tb_drum_step_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 55;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_item_t             req       = '0;
    logic                  msg_valid;
    logic                  msg_ready = 1'b0;
    midi_msg_t             msg;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int due_count;

    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit rx_hold_req = 1'b0;
    bit tb_playing  = 1'b0;
    int loop_span   = 16;

    drum_step_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dss_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .msg_valid  (msg_valid),
        .msg_ready  (msg_ready),
        .msg        (msg),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatch_count),
        .pending    (due_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, calm stretches, and one long hold on request
    initial
    begin : receiver
        int stall;
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                msg_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = rx_calm ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            if (stall > 0)
            begin
                msg_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            msg_ready <= 1'b1;
            do @(posedge clk); while (!msg_valid);
        end
    end

    function automatic req_item_t noise_item(input logic [1:0] kind);
        req_item_t r;
        r                 = '0;
        r.req_type        = kind;
        r.cell_instrument = INST_W'($urandom);
        r.cell_step       = STEP_W'($urandom);
        r.cell_value      = 1'($urandom);
        return r;
    endfunction

    function automatic req_item_t cell_item(input int inst, input int col, input bit val);
        req_item_t r;
        r                 = '0;
        r.req_type        = REQ_WRITE;
        r.cell_instrument = INST_W'(inst);
        r.cell_step       = STEP_W'(col);
        r.cell_value      = val;
        return r;
    endfunction

    function automatic req_item_t random_item();
        req_item_t r;
        int        pick;
        r    = noise_item(REQ_TICK);
        pick = $urandom_range(0, 99);
        // restart playback now and then instead of ticking into nothing
        if (!tb_playing && pick < 45 && $urandom_range(0, 2) != 0)
            pick = 88;
        if (pick < 45)
            r.req_type = REQ_TICK;
        else if (pick < 85)
        begin
            r.req_type = REQ_WRITE;
            if ($urandom_range(0, 4) != 0)
                r.cell_step = STEP_W'($urandom_range(0, loop_span - 1));
            r.cell_value = ($urandom_range(0, 99) < 60);
        end
        else if (pick < 94)
            r.req_type = REQ_START;
        else
            r.req_type = REQ_STOP;
        return r;
    endfunction

    task automatic offer_request(input req_item_t item);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        if (item.req_type == REQ_START)
            tb_playing = 1'b1;
        else if (item.req_type == REQ_STOP)
            tb_playing = 1'b0;
    endtask

    task automatic drain_messages();
        req_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drain, let a message-less request finish, then set both registers
    task automatic set_loop(input logic [7:0] steps, input logic [6:0] vel);
        drain_messages();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_STEPS_IN_LOOP, steps);
        write_reg(CFG_NOTE_VELOCITY, {1'b0, vel});
        if (steps == 8'd0)
            loop_span = 1;
        else if (steps > 8'd128)
            loop_span = 128;
        else
            loop_span = int'(steps);
    endtask

    task automatic random_phase(input int count);
        req_item_t item;
        int        n;
        n = 0;
        while (n < count)
        begin
            item = random_item();
            // ticks while stopped are dropped by the block
            if (!(item.req_type == REQ_TICK && !tb_playing))
                n++;
            offer_request(item);
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] loop_set [0:6];
        logic [6:0] vel_set  [0:6];
        loop_set = '{8'd1, 8'd128, 8'd0, 8'd2, 8'd255, 8'd8, 8'd37};
        vel_set  = '{7'd0, 7'd64, 7'd1, 7'd127, 7'd100, 7'd33, 7'd90};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle requests, corner cells, lagging note-offs, restart
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_STOP));
        offer_request(cell_item(31, 127, 1'b1));
        offer_request(cell_item(0, 0, 1'b1));
        offer_request(cell_item(31, 0, 1'b1));
        offer_request(cell_item(5, 1, 1'b1));
        offer_request(cell_item(9, 1, 1'b1));
        offer_request(cell_item(9, 1, 1'b0));
        offer_request(cell_item(20, 127, 1'b0));
        offer_request(noise_item(REQ_START));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_START));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_STOP));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_START));
        offer_request(noise_item(REQ_TICK));
        offer_request(noise_item(REQ_STOP));

        for (int p = 0; p < 7; p++)
        begin
            set_loop(loop_set[p], vel_set[p]);
            random_phase(PHASE_ITEMS);
            if (p == 3)
            begin
                // Fill two columns, loop over them and hold the receiver off
                set_loop(8'd2, 7'd127);
                write_reg(CFG_SPARE, 8'hFF);
                for (int s = 0; s < 2; s++)
                    for (int i = 0; i < 32; i++)
                        offer_request(cell_item(i, s, 1'b1));
                offer_request(noise_item(REQ_START));
                offer_request(noise_item(REQ_TICK));
                rx_hold_req = 1'b1;
                repeat (4) offer_request(noise_item(REQ_TICK));
                drain_messages();
            end
        end

        drain_messages();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && due_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dss_pkg.sv
rtl/dss_ctrl.sv
rtl/dss_datapath.sv
rtl/drum_step_sequencer_core.sv
test/dss_checker.sv
test/tb_drum_step_sequencer_core.sv
